// File: hdl/sccl_pkg.sv
// Package: payload types, codes and controller states for the condensed longest-path engine.
package sccl_pkg;

    localparam int ID_W     = 11;
    localparam int REWARD_W = 16;
    localparam int TOTAL_W  = 27;
    localparam int KIND_W   = 2;

    // Transaction kinds; the fourth code is ignored.
    localparam logic [KIND_W-1:0] KIND_NODE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     node_id;
        logic                is_office;
        logic [REWARD_W-1:0] reward;
        logic [ID_W-1:0]     edge_from;
        logic [ID_W-1:0]     edge_to;
    } item_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] best_total;
        logic                      edges_dropped;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_B_RD,
        ST_B_HD,
        ST_B_WR,
        ST_P1_ROOT,
        ST_P1_RCHK,
        ST_P1_HEAD,
        ST_P1_PTR,
        ST_P1_EDGE,
        ST_P1_VIS,
        ST_P1_TOP,
        ST_P2_ROOT,
        ST_P2_RD,
        ST_P2_RCHK,
        ST_P2_ACC,
        ST_P2_HEAD,
        ST_P2_PTR,
        ST_P2_EDGE,
        ST_P2_VIS,
        ST_P2_PRED,
        ST_P2_TOP,
        ST_P2_DONE,
        ST_FINISH
    } state_t;

endpackage

// File: hdl/sccl_stream_if.sv
// Valid/ready stream interface carrying one packed payload.
interface sccl_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/sccl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sccl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/scc_condensed_longest_path_core.sv
// Top level: strongly connected components and longest reward path over their DAG.
// Node and edge transactions load while idle without stalling the input (ready stays high in idle).
// A run transaction builds the adjacency lists, then does a forward walk and a reverse walk,
//   paced by the single read port of each memory.
// The result is registered; afterwards a clear sweep over all MAX_NODES entries erases node data.
// Reset (rst_n low, async) starts the same clear sweep; node_count resets to 1.
module scc_condensed_longest_path_core
    import sccl_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int REWARD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ID_W-1:0]     cfg_wr_data,
    sccl_stream_if.sink         item,
    sccl_stream_if.source       result
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int CNT_W  = NODE_W + 1;
    localparam int ECNT_W = EDGE_W + 1;
    localparam int LINK_W = EDGE_W + 1;           // {valid, edge index}
    localparam int NS_W   = NODE_W + 1;           // {mark, component}
    localparam int RW     = (REWARD_BITS < REWARD_W) ? REWARD_BITS : REWARD_W;
    localparam int SUM_W  = RW + NODE_W;
    localparam int CB_W   = SUM_W + 1;            // {reached, best}

    // Control registers
    state_t              state_reg, state_next;
    logic [ID_W-1:0]     node_count_reg, node_count_next;
    logic [ECNT_W-1:0]   edges_reg, edges_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    clr_reg, clr_next;
    logic [ECNT_W-1:0]   e_reg, e_next;
    logic [CNT_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    fcount_reg, fcount_next;
    logic [CNT_W-1:0]    sp_reg, sp_next;
    logic [CNT_W-1:0]    ccount_reg, ccount_next;
    logic                found_reg, found_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [NODE_W-1:0]   s_reg, s_next;
    logic [NODE_W-1:0]   t_reg, t_next;
    logic [NODE_W-1:0]   c_reg, c_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    maxpred_reg, maxpred_next;
    logic [SUM_W-1:0]    ans_reg, ans_next;
    logic                office_reg, office_next;
    logic                start_reg, start_next;
    logic                predreach_reg, predreach_next;
    result_t             out_reg, out_next;

    // Memory ports
    logic                nm_we;
    logic [NODE_W-1:0]   nm_wa, nm_ra;
    logic [RW:0]         nm_wd, nm_rd;
    logic                em_we;
    logic [EDGE_W-1:0]   em_wa, em_ra;
    logic [2*NODE_W-1:0] em_wd, em_rd;
    logic                fh_we, rh_we, fn_we, rn_we;
    logic [NODE_W-1:0]   fh_wa, fh_ra, rh_wa, rh_ra;
    logic [EDGE_W-1:0]   fn_wa, fn_ra, rn_wa, rn_ra;
    logic [LINK_W-1:0]   fh_wd, fh_rd, rh_wd, rh_rd, fn_wd, fn_rd, rn_wd, rn_rd;
    logic                ns_we;
    logic [NODE_W-1:0]   ns_wa, ns_ra;
    logic [NS_W-1:0]     ns_wd, ns_rd;
    logic                st_we;
    logic [NODE_W-1:0]   st_wa, st_ra, st_wd, st_rd;
    logic                fo_we;
    logic [NODE_W-1:0]   fo_wa, fo_ra, fo_wd, fo_rd;
    logic                cb_we;
    logic [NODE_W-1:0]   cb_wa, cb_ra;
    logic [CB_W-1:0]     cb_wd, cb_rd;

    logic                item_acc, result_acc;
    logic [NODE_W-1:0]   em_src, em_tgt;
    logic                ns_mark;
    logic [NODE_W-1:0]   ns_comp;
    logic                ends_ok, last_edge, last_root;
    logic [CNT_W-1:0]    n_clamp;
    logic [SUM_W-1:0]    comp_best;
    logic                comp_reached;

    assign item_acc     = item.valid && item.ready;
    assign result_acc   = result.valid && result.ready;
    assign em_src       = em_rd[2*NODE_W-1:NODE_W];
    assign em_tgt       = em_rd[NODE_W-1:0];
    assign ns_mark      = ns_rd[NS_W-1];
    assign ns_comp      = ns_rd[NODE_W-1:0];
    assign ends_ok      = ({1'b0, em_src} < n_reg) && ({1'b0, em_tgt} < n_reg);
    assign last_edge    = (e_reg + ECNT_W'(1)) == edges_reg;
    assign last_root    = (r_reg + CNT_W'(1)) == n_reg;
    assign comp_best    = sum_reg + maxpred_reg;
    assign comp_reached = start_reg || predreach_reg;

    // Node count outside 1..MAX_NODES saturates
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            n_clamp = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_clamp = CNT_W'(node_count_reg);
        end
    end

    // Memories: loaded node data, stored edges, forward/reverse adjacency lists
    // (head per node, next per edge; heads double as walk positions), node
    // marks with component ids, walk stack, finish order, per-component best.
    sccl_ram #(.WIDTH(RW + 1), .DEPTH(MAX_NODES)) u_node_mem (
        .clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd));
    sccl_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_EDGES)) u_edge_mem (
        .clk(clk), .we(em_we), .waddr(em_wa), .wdata(em_wd), .raddr(em_ra), .rdata(em_rd));
    sccl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_fwd_head (
        .clk(clk), .we(fh_we), .waddr(fh_wa), .wdata(fh_wd), .raddr(fh_ra), .rdata(fh_rd));
    sccl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_rev_head (
        .clk(clk), .we(rh_we), .waddr(rh_wa), .wdata(rh_wd), .raddr(rh_ra), .rdata(rh_rd));
    sccl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_EDGES)) u_fwd_next (
        .clk(clk), .we(fn_we), .waddr(fn_wa), .wdata(fn_wd), .raddr(fn_ra), .rdata(fn_rd));
    sccl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_EDGES)) u_rev_next (
        .clk(clk), .we(rn_we), .waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_rd));
    sccl_ram #(.WIDTH(NS_W), .DEPTH(MAX_NODES)) u_node_state (
        .clk(clk), .we(ns_we), .waddr(ns_wa), .wdata(ns_wd), .raddr(ns_ra), .rdata(ns_rd));
    sccl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
    sccl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_finish (
        .clk(clk), .we(fo_we), .waddr(fo_wa), .wdata(fo_wd), .raddr(fo_ra), .rdata(fo_rd));
    sccl_ram #(.WIDTH(CB_W), .DEPTH(MAX_NODES)) u_comp_best (
        .clk(clk), .we(cb_we), .waddr(cb_wa), .wdata(cb_wd), .raddr(cb_ra), .rdata(cb_rd));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CNT_W'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_acc && item.data.kind == KIND_RUN)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (clr_reg == n_reg - CNT_W'(1))
                begin
                    state_next = (edges_reg == '0) ? ST_P1_ROOT : ST_B_RD;
                end
            end
            ST_B_RD:    state_next = ST_B_HD;
            ST_B_HD:
            begin
                if (ends_ok)
                begin
                    state_next = ST_B_WR;
                end
                else
                begin
                    state_next = last_edge ? ST_P1_ROOT : ST_B_RD;
                end
            end
            ST_B_WR:    state_next = last_edge ? ST_P1_ROOT : ST_B_RD;
            ST_P1_ROOT: state_next = ST_P1_RCHK;
            ST_P1_RCHK:
            begin
                if (ns_mark)
                begin
                    state_next = last_root ? ST_P2_ROOT : ST_P1_ROOT;
                end
                else
                begin
                    state_next = ST_P1_HEAD;
                end
            end
            ST_P1_HEAD: state_next = ST_P1_PTR;
            ST_P1_PTR:
            begin
                if (fh_rd[LINK_W-1])
                begin
                    state_next = ST_P1_EDGE;
                end
                else if (sp_reg == CNT_W'(1))
                begin
                    state_next = last_root ? ST_P2_ROOT : ST_P1_ROOT;
                end
                else
                begin
                    state_next = ST_P1_TOP;
                end
            end
            ST_P1_EDGE: state_next = ST_P1_VIS;
            ST_P1_VIS:  state_next = ST_P1_HEAD;
            ST_P1_TOP:  state_next = ST_P1_HEAD;
            ST_P2_ROOT: state_next = ST_P2_RD;
            ST_P2_RD:   state_next = ST_P2_RCHK;
            ST_P2_RCHK:
            begin
                if (ns_mark)
                begin
                    state_next = ST_P2_ACC;
                end
                else
                begin
                    state_next = (i_reg == CNT_W'(1)) ? ST_FINISH : ST_P2_ROOT;
                end
            end
            ST_P2_ACC:  state_next = ST_P2_HEAD;
            ST_P2_HEAD: state_next = ST_P2_PTR;
            ST_P2_PTR:
            begin
                if (rh_rd[LINK_W-1])
                begin
                    state_next = ST_P2_EDGE;
                end
                else if (sp_reg == CNT_W'(1))
                begin
                    state_next = ST_P2_DONE;
                end
                else
                begin
                    state_next = ST_P2_TOP;
                end
            end
            ST_P2_EDGE: state_next = ST_P2_VIS;
            ST_P2_VIS:
            begin
                if (ns_mark)
                begin
                    state_next = ST_P2_ACC;
                end
                else if (ns_comp != c_reg)
                begin
                    state_next = ST_P2_PRED;
                end
                else
                begin
                    state_next = ST_P2_HEAD;
                end
            end
            ST_P2_PRED: state_next = ST_P2_HEAD;
            ST_P2_TOP:  state_next = ST_P2_HEAD;
            ST_P2_DONE: state_next = (i_reg == CNT_W'(1)) ? ST_FINISH : ST_P2_ROOT;
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;
        edges_next      = edges_reg;
        ovf_next        = ovf_reg;
        n_next          = n_reg;
        clr_next        = clr_reg;
        e_next          = e_reg;
        r_next          = r_reg;
        i_next          = i_reg;
        fcount_next     = fcount_reg;
        sp_next         = sp_reg;
        ccount_next     = ccount_reg;
        found_next      = found_reg;
        out_valid_next  = result_acc ? 1'b0 : out_valid_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        s_next          = s_reg;
        t_next          = t_reg;
        c_next          = c_reg;
        sum_next        = sum_reg;
        maxpred_next    = maxpred_reg;
        ans_next        = ans_reg;
        office_next     = office_reg;
        start_next      = start_reg;
        predreach_next  = predreach_reg;
        out_next        = out_reg;

        nm_we = 1'b0;  nm_wa = '0;  nm_wd = '0;  nm_ra = u_reg;
        em_we = 1'b0;  em_wa = '0;  em_wd = '0;  em_ra = '0;
        fh_we = 1'b0;  fh_wa = '0;  fh_wd = '0;  fh_ra = u_reg;
        rh_we = 1'b0;  rh_wa = '0;  rh_wd = '0;  rh_ra = u_reg;
        fn_we = 1'b0;  fn_wa = '0;  fn_wd = '0;  fn_ra = '0;
        rn_we = 1'b0;  rn_wa = '0;  rn_wd = '0;  rn_ra = '0;
        ns_we = 1'b0;  ns_wa = '0;  ns_wd = '0;  ns_ra = '0;
        st_we = 1'b0;  st_wa = '0;  st_wd = '0;  st_ra = '0;
        fo_we = 1'b0;  fo_wa = '0;  fo_wd = '0;  fo_ra = '0;
        cb_we = 1'b0;  cb_wa = '0;  cb_wd = '0;  cb_ra = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                nm_we    = 1'b1;
                nm_wa    = clr_reg[NODE_W-1:0];
                clr_next = clr_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.data.kind == KIND_NODE)
                    begin
                        if (item.data.node_id != '0 && 32'(item.data.node_id) <= MAX_NODES)
                        begin
                            nm_we = 1'b1;
                            nm_wa = NODE_W'(item.data.node_id - ID_W'(1));
                            nm_wd = {item.data.is_office, item.data.reward[RW-1:0]};
                        end
                    end
                    else if (item.data.kind == KIND_EDGE)
                    begin
                        if (item.data.edge_from != '0 && 32'(item.data.edge_from) <= MAX_NODES
                            && item.data.edge_to != '0 && 32'(item.data.edge_to) <= MAX_NODES)
                        begin
                            if (edges_reg < ECNT_W'(MAX_EDGES))
                            begin
                                em_we      = 1'b1;
                                em_wa      = edges_reg[EDGE_W-1:0];
                                em_wd      = {NODE_W'(item.data.edge_from - ID_W'(1)),
                                              NODE_W'(item.data.edge_to - ID_W'(1))};
                                edges_next = edges_reg + ECNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    else if (item.data.kind == KIND_RUN)
                    begin
                        n_next   = n_clamp;
                        clr_next = '0;
                    end
                end
            end
            ST_INIT:
            begin
                fh_we       = 1'b1;
                fh_wa       = clr_reg[NODE_W-1:0];
                rh_we       = 1'b1;
                rh_wa       = clr_reg[NODE_W-1:0];
                ns_we       = 1'b1;
                ns_wa       = clr_reg[NODE_W-1:0];
                clr_next    = clr_reg + CNT_W'(1);
                e_next      = '0;
                r_next      = '0;
                fcount_next = '0;
                ccount_next = '0;
                found_next  = 1'b0;
                ans_next    = '0;
            end
            ST_B_RD:
            begin
                em_ra = e_reg[EDGE_W-1:0];
            end
            ST_B_HD:
            begin
                fh_ra  = em_src;
                rh_ra  = em_tgt;
                s_next = em_src;
                t_next = em_tgt;
                if (!ends_ok)
                begin
                    e_next = e_reg + ECNT_W'(1);
                end
            end
            ST_B_WR:
            begin
                // push edge on the front of both lists
                fn_we  = 1'b1;
                fn_wa  = e_reg[EDGE_W-1:0];
                fn_wd  = fh_rd;
                fh_we  = 1'b1;
                fh_wa  = s_reg;
                fh_wd  = {1'b1, e_reg[EDGE_W-1:0]};
                rn_we  = 1'b1;
                rn_wa  = e_reg[EDGE_W-1:0];
                rn_wd  = rh_rd;
                rh_we  = 1'b1;
                rh_wa  = t_reg;
                rh_wd  = {1'b1, e_reg[EDGE_W-1:0]};
                e_next = e_reg + ECNT_W'(1);
            end
            ST_P1_ROOT:
            begin
                ns_ra = r_reg[NODE_W-1:0];
            end
            ST_P1_RCHK:
            begin
                if (ns_mark)
                begin
                    r_next = r_reg + CNT_W'(1);
                end
                else
                begin
                    ns_we   = 1'b1;
                    ns_wa   = r_reg[NODE_W-1:0];
                    ns_wd   = {1'b1, NODE_W'(0)};
                    st_we   = 1'b1;
                    st_wa   = '0;
                    st_wd   = r_reg[NODE_W-1:0];
                    sp_next = CNT_W'(1);
                    u_next  = r_reg[NODE_W-1:0];
                end
            end
            ST_P1_HEAD:
            begin
                fh_ra = u_reg;
            end
            ST_P1_PTR:
            begin
                if (fh_rd[LINK_W-1])
                begin
                    em_ra = fh_rd[EDGE_W-1:0];
                    fn_ra = fh_rd[EDGE_W-1:0];
                end
                else
                begin
                    fo_we       = 1'b1;
                    fo_wa       = fcount_reg[NODE_W-1:0];
                    fo_wd       = u_reg;
                    fcount_next = fcount_reg + CNT_W'(1);
                    sp_next     = sp_reg - CNT_W'(1);
                    if (sp_reg == CNT_W'(1))
                    begin
                        r_next = r_reg + CNT_W'(1);
                    end
                    else
                    begin
                        st_ra = NODE_W'(sp_reg - CNT_W'(2));
                    end
                end
            end
            ST_P1_EDGE:
            begin
                fh_we  = 1'b1;
                fh_wa  = u_reg;
                fh_wd  = fn_rd;
                v_next = em_tgt;
                ns_ra  = em_tgt;
            end
            ST_P1_VIS:
            begin
                if (!ns_mark)
                begin
                    ns_we   = 1'b1;
                    ns_wa   = v_reg;
                    ns_wd   = {1'b1, NODE_W'(0)};
                    st_we   = 1'b1;
                    st_wa   = sp_reg[NODE_W-1:0];
                    st_wd   = v_reg;
                    sp_next = sp_reg + CNT_W'(1);
                    u_next  = v_reg;
                end
            end
            ST_P1_TOP:
            begin
                u_next = st_rd;
            end
            ST_P2_ROOT:
            begin
                fo_ra = NODE_W'(i_reg - CNT_W'(1));
            end
            ST_P2_RD:
            begin
                ns_ra  = fo_rd;
                u_next = fo_rd;
            end
            ST_P2_RCHK:
            begin
                if (ns_mark)
                begin
                    // open a new component rooted here
                    c_next         = ccount_reg[NODE_W-1:0];
                    ccount_next    = ccount_reg + CNT_W'(1);
                    sum_next       = '0;
                    maxpred_next   = '0;
                    office_next    = 1'b0;
                    start_next     = 1'b0;
                    predreach_next = 1'b0;
                    ns_we          = 1'b1;
                    ns_wa          = u_reg;
                    ns_wd          = {1'b0, ccount_reg[NODE_W-1:0]};
                    nm_ra          = u_reg;
                    st_we          = 1'b1;
                    st_wa          = '0;
                    st_wd          = u_reg;
                    sp_next        = CNT_W'(1);
                end
                else
                begin
                    i_next = i_reg - CNT_W'(1);
                end
            end
            ST_P2_ACC:
            begin
                sum_next    = sum_reg + SUM_W'(nm_rd[RW-1:0]);
                office_next = office_reg || nm_rd[RW];
                if (u_reg == '0)
                begin
                    start_next = 1'b1;
                end
            end
            ST_P2_HEAD:
            begin
                rh_ra = u_reg;
            end
            ST_P2_PTR:
            begin
                if (rh_rd[LINK_W-1])
                begin
                    em_ra = rh_rd[EDGE_W-1:0];
                    rn_ra = rh_rd[EDGE_W-1:0];
                end
                else
                begin
                    sp_next = sp_reg - CNT_W'(1);
                    if (sp_reg != CNT_W'(1))
                    begin
                        st_ra = NODE_W'(sp_reg - CNT_W'(2));
                    end
                end
            end
            ST_P2_EDGE:
            begin
                rh_we  = 1'b1;
                rh_wa  = u_reg;
                rh_wd  = rn_rd;
                v_next = em_src;
                ns_ra  = em_src;
            end
            ST_P2_VIS:
            begin
                if (ns_mark)
                begin
                    ns_we   = 1'b1;
                    ns_wa   = v_reg;
                    ns_wd   = {1'b0, c_reg};
                    nm_ra   = v_reg;
                    st_we   = 1'b1;
                    st_wa   = sp_reg[NODE_W-1:0];
                    st_wd   = v_reg;
                    sp_next = sp_reg + CNT_W'(1);
                    u_next  = v_reg;
                end
                else
                begin
                    // node already in a component; if another one, a final predecessor
                    cb_ra = ns_comp;
                end
            end
            ST_P2_PRED:
            begin
                if (cb_rd[CB_W-1])
                begin
                    predreach_next = 1'b1;
                    if (cb_rd[SUM_W-1:0] > maxpred_reg)
                    begin
                        maxpred_next = cb_rd[SUM_W-1:0];
                    end
                end
            end
            ST_P2_TOP:
            begin
                u_next = st_rd;
            end
            ST_P2_DONE:
            begin
                cb_we  = 1'b1;
                cb_wa  = c_reg;
                cb_wd  = {comp_reached, comp_best};
                i_next = i_reg - CNT_W'(1);
                if (office_reg && comp_reached)
                begin
                    found_next = 1'b1;
                    if (!found_reg || comp_best > ans_reg)
                    begin
                        ans_next = comp_best;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.best_total    = found_reg ? TOTAL_W'(ans_reg) : '1;
                    out_next.edges_dropped = ovf_reg;
                    clr_next               = '0;
                    edges_next             = '0;
                    ovf_next               = 1'b0;
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase

        // reverse walk starts from the last finished node
        if (state_next == ST_P2_ROOT
            && (state_reg == ST_P1_RCHK || state_reg == ST_P1_PTR))
        begin
            i_next = fcount_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= ID_W'(1);
            edges_reg      <= '0;
            ovf_reg        <= 1'b0;
            n_reg          <= CNT_W'(1);
            clr_reg        <= '0;
            e_reg          <= '0;
            r_reg          <= '0;
            i_reg          <= '0;
            fcount_reg     <= '0;
            sp_reg         <= '0;
            ccount_reg     <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edges_reg      <= edges_next;
            ovf_reg        <= ovf_next;
            n_reg          <= n_next;
            clr_reg        <= clr_next;
            e_reg          <= e_next;
            r_reg          <= r_next;
            i_reg          <= i_next;
            fcount_reg     <= fcount_next;
            sp_reg         <= sp_next;
            ccount_reg     <= ccount_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        v_reg         <= v_next;
        s_reg         <= s_next;
        t_reg         <= t_next;
        c_reg         <= c_next;
        sum_reg       <= sum_next;
        maxpred_reg   <= maxpred_next;
        ans_reg       <= ans_next;
        office_reg    <= office_next;
        start_reg     <= start_next;
        predreach_reg <= predreach_next;
        out_reg       <= out_next;
    end

    // Ports
    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// File: hdl/sccl_checker.sv
// Port-level checker for the condensed longest-path core, with its bind.
module sccl_checker
    import sccl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic [KIND_W-1:0]  item_kind,
    input logic               result_valid,
    input logic               result_ready,
    input logic [TOTAL_W-1:0] result_best
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_best))
        else $error("result transaction dropped or changed while stalled");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_kind == KIND_RUN |=> !item_ready)
        else $error("run transaction did not make the core busy");

    a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_kind != KIND_RUN |=> item_ready)
        else $error("load transaction stalled the input");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !item_ready)
        else $error("result appeared outside a run");

endmodule

bind scc_condensed_longest_path_core sccl_checker u_sccl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.data.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_best  (result.data.best_total)
);
